// ----- hw/rtl/dit_pkg.sv -----
`default_nettype none
package dit_pkg;
    localparam int MaxIntervals = 16;
    localparam int ValueBits    = 16;
    localparam int IdxBits      = $clog2(MaxIntervals);
    localparam int CntBits      = $clog2(MaxIntervals + 1);
    localparam int QueueDepth   = 2;

    typedef logic [ValueBits-1:0] t_value;
    typedef logic [IdxBits-1:0]   t_idx;
    typedef logic [CntBits-1:0]   t_cnt;

    localparam logic       OpAdd    = 1'b0;
    localparam logic       OpReport = 1'b1;

    localparam logic [1:0] KindAck   = 2'd0;
    localparam logic [1:0] KindEntry = 2'd1;
    localparam logic [1:0] KindEmpty = 2'd2;

    localparam logic [1:0] StCovered = 2'd0;
    localparam logic [1:0] StNew     = 2'd1;
    localparam logic [1:0] StJoined  = 2'd2;
    localparam logic [1:0] StDropped = 2'd3;

    typedef struct packed {
        logic   op;
        t_value value;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_REPORT
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/dit_if.sv -----
`default_nettype none
interface dit_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] add_value;
    modport source (output valid, operation, add_value, input ready);
    modport sink   (input valid, operation, add_value, output ready);
endinterface

interface dit_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  add_status;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic        last_of_run;
    modport source (output valid, result_kind, add_status, range_start, range_end,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, add_status, range_start, range_end,
                    last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dit_front.sv -----
`default_nettype none
module dit_front
    import dit_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    dit_in_if.sink i_in,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  wire  i_cmd_pop
);
    t_cmd r_q [QueueDepth];
    logic [1:0] r_cnt, n_cnt;
    logic push;
    t_cmd in_word;

    assign i_in.ready  = (r_cnt < 2'(QueueDepth));
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[0];
    assign in_word     = '{i_in.operation, t_value'(i_in.add_value)};

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        // Incoming words land in the first free slot after any pop.
        if (i_cmd_pop) begin
            if (push && r_cnt == 2'd1) begin
                r_q[0] <= in_word;
            end else begin
                r_q[0] <= r_q[1];
            end
        end else if (push && r_cnt == 2'd0) begin
            r_q[0] <= in_word;
        end
        if (push && (r_cnt - 2'(i_cmd_pop)) == 2'd1) begin
            r_q[1] <= in_word;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QueueDepth) |-> !i_in.ready) else $error("ready while full");
endmodule
`default_nettype wire

// ----- hw/rtl/dit_back.sv -----
`default_nettype none
module dit_back
    import dit_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    dit_out_if.source o_out
);
    t_value r_lo [MaxIntervals];
    t_value r_hi [MaxIntervals];
    t_cnt   r_n;
    t_state r_state, n_state;
    t_idx   r_ri;
    t_cmd   r_cmd;

    logic        r_ov;
    logic [1:0]  r_kind, r_st;
    logic [15:0] r_s, r_e;
    logic        r_last;
    logic        out_free;
    logic        emit;

    assign out_free = !r_ov || o_out.ready;
    // A new word is loaded into the result register in this cycle.
    assign emit     = (r_state != S_IDLE) && out_free;

    // Parallel search: slot of first interval with start above value, and cover.
    t_cnt   pos;
    logic   cov;
    t_idx   cov_i;
    always_comb begin
        pos   = r_n;
        cov   = 1'b0;
        cov_i = '0;
        for (int k = MaxIntervals - 1; k >= 0; k--) begin
            if (t_cnt'(k) < r_n) begin
                if (r_lo[k] > r_cmd.value) pos = t_cnt'(k);
                if (r_lo[k] <= r_cmd.value && r_hi[k] >= r_cmd.value) begin
                    cov   = 1'b1;
                    cov_i = t_idx'(k);
                end
            end
        end
    end

    logic join_lo, join_hi;
    t_idx pi, pm;
    always_comb begin
        pi = t_idx'(pos);
        pm = t_idx'(pos - t_cnt'(1));
        join_lo = (pos != '0) && (r_cmd.value != '0) &&
                  (r_hi[pm] == r_cmd.value - t_value'(1));
        join_hi = (pos < r_n) && (r_cmd.value != '1) &&
                  (r_lo[pi] == r_cmd.value + t_value'(1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_cmd_valid) n_state = (i_cmd.op == OpReport) ? S_REPORT : S_ADD;
            S_ADD:    if (out_free) n_state = S_IDLE;
            S_REPORT: if (out_free && (r_n == '0 || t_cnt'(r_ri) + t_cnt'(1) >= r_n))
                          n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_ov    <= 1'b0;
            r_ri    <= '0;
        end else begin
            r_state <= n_state;
            if (o_out.ready && !emit) r_ov <= 1'b0;
            if (o_cmd_pop) begin
                r_cmd <= i_cmd;
                r_ri  <= '0;
            end
            if (r_state == S_ADD && out_free) begin
                r_ov <= 1'b1; r_kind <= KindAck; r_last <= 1'b1;
                if (cov) begin
                    r_st <= StCovered;
                    r_s  <= 16'(r_lo[cov_i]); r_e <= 16'(r_hi[cov_i]);
                end else if (join_lo && join_hi) begin
                    r_st <= StJoined;
                    r_s  <= 16'(r_lo[pm]); r_e <= 16'(r_hi[pi]);
                    r_hi[pm] <= r_hi[pi];
                    for (int k = 0; k < MaxIntervals - 1; k++)
                        if (t_cnt'(k) >= pos) begin
                            r_lo[k] <= r_lo[k+1]; r_hi[k] <= r_hi[k+1];
                        end
                    r_n <= r_n - t_cnt'(1);
                end else if (join_lo) begin
                    r_st <= StJoined;
                    r_s  <= 16'(r_lo[pm]); r_e <= 16'(r_cmd.value);
                    r_hi[pm] <= r_cmd.value;
                end else if (join_hi) begin
                    r_st <= StJoined;
                    r_s  <= 16'(r_cmd.value); r_e <= 16'(r_hi[pi]);
                    r_lo[pi] <= r_cmd.value;
                end else if (r_n >= t_cnt'(MaxIntervals)) begin
                    r_st <= StDropped; r_s <= '0; r_e <= '0;
                end else begin
                    r_st <= StNew;
                    r_s  <= 16'(r_cmd.value); r_e <= 16'(r_cmd.value);
                    for (int k = 1; k < MaxIntervals; k++)
                        if (t_cnt'(k) > pos) begin
                            r_lo[k] <= r_lo[k-1]; r_hi[k] <= r_hi[k-1];
                        end
                    r_lo[pi] <= r_cmd.value; r_hi[pi] <= r_cmd.value;
                    r_n <= r_n + t_cnt'(1);
                end
            end
            if (r_state == S_REPORT && out_free) begin
                r_ov <= 1'b1; r_st <= StCovered;
                if (r_n == '0) begin
                    r_kind <= KindEmpty; r_s <= '0; r_e <= '0; r_last <= 1'b1;
                end else begin
                    r_kind <= KindEntry;
                    r_s <= 16'(r_lo[r_ri]); r_e <= 16'(r_hi[r_ri]);
                    r_last <= (t_cnt'(r_ri) + t_cnt'(1) >= r_n);
                    r_ri <= r_ri + t_idx'(1);
                end
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.result_kind = r_kind;
    assign o_out.add_status  = r_st;
    assign o_out.range_start = r_s;
    assign o_out.range_end   = r_e;
    assign o_out.last_of_run = r_last;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= t_cnt'(MaxIntervals)) else $error("count beyond table");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_s) && $stable(r_e))
        else $error("result lost under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == S_IDLE) else $error("pop while busy");
endmodule
`default_nettype wire

// ----- hw/rtl/disjoint_interval_tracker_core.sv -----
// Disjoint interval tracker.
// Input channel (dit_in_if): operation 0 adds add_value to the set, 1 asks
// for a report of every stored interval in ascending order.
// Output channel (dit_out_if): one acknowledgement word per add, carrying
// status and resulting interval; a report gives one word per interval with
// last_of_run on the final one, or a single empty-table word.
// A two-word queue parts the accepting front from the executing back, so
// words are taken while the back is busy or the output is stalled.
// An add goes from the queue to the back's command register (dispatch),
// then executes with a parallel compare over all slots and a table shift,
// loading its ack into the result register; a report gives its first
// word the same way and one more word per cycle while the receiver keeps
// up. The back pops a new command only when idle, after the last is done.
// Reset clears the interval count, the queue and the result valid flag; the
// table contents are not cleared. When the receiver stalls, the result
// register holds its word and the back waits; the front fills and then
// drops ready.
`default_nettype none
module disjoint_interval_tracker_core
    import dit_pkg::*;
(
    input wire i_clk,
    input wire i_rst_n,
    dit_in_if.sink     i_in,
    dit_out_if.source  o_out
);
    logic o_cmd_valid_w, pop;
    t_cmd cmd;

    dit_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_cmd_valid(o_cmd_valid_w), .o_cmd(cmd), .i_cmd_pop(pop)
    );
    dit_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(o_cmd_valid_w), .i_cmd(cmd), .o_cmd_pop(pop), .o_out
    );
endmodule
`default_nettype wire

// ----- dv/disjoint_interval_tracker_core_tb.sv -----
module disjoint_interval_tracker_core_tb;
    import dit_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        last;
    } t_word;

    localparam int StallLimit = 4000;
    localparam logic [15:0] TopValue = 16'hFFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dit_in_if  cmd_ch ();
    dit_out_if res_ch ();

    disjoint_interval_tracker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_cmd  pending_cmds[$];
    t_word expected_words[$];

    t_value iv_lo[MaxIntervals];
    t_value iv_hi[MaxIntervals];
    int     iv_count;

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int adds_seen;
    int reports_seen;
    int words_checked;

    // Works out the words one command causes and updates the interval table.
    function automatic void track_command(input t_cmd c);
        t_word w;
        int i;
        int j;
        bit join_lo;
        bit join_hi;
        t_value v;
        v = c.value;
        if (c.op == OpReport) begin
            reports_seen++;
            if (iv_count == 0) begin
                w = '{KindEmpty, StCovered, 16'd0, 16'd0, 1'b1};
                expected_words.push_back(w);
            end else begin
                for (i = 0; i < iv_count; i++) begin
                    w = '{KindEntry, StCovered, iv_lo[i], iv_hi[i], i == iv_count - 1};
                    expected_words.push_back(w);
                end
            end
            return;
        end
        adds_seen++;
        for (i = 0; i < iv_count; i++) begin
            if (iv_lo[i] <= v && iv_hi[i] >= v) begin
                w = '{KindAck, StCovered, iv_lo[i], iv_hi[i], 1'b1};
                expected_words.push_back(w);
                return;
            end
            if (iv_lo[i] > v) break;
        end
        join_lo = (i > 0) && (v != 0) && (iv_hi[i-1] == v - 16'd1);
        join_hi = (i < iv_count) && (v != TopValue) && (iv_lo[i] == v + 16'd1);
        if (join_lo && join_hi) begin
            iv_hi[i-1] = iv_hi[i];
            for (j = i; j + 1 < iv_count; j++) begin
                iv_lo[j] = iv_lo[j+1];
                iv_hi[j] = iv_hi[j+1];
            end
            iv_count--;
            w = '{KindAck, StJoined, iv_lo[i-1], iv_hi[i-1], 1'b1};
        end else if (join_lo) begin
            iv_hi[i-1] = v;
            w = '{KindAck, StJoined, iv_lo[i-1], v, 1'b1};
        end else if (join_hi) begin
            iv_lo[i] = v;
            w = '{KindAck, StJoined, v, iv_hi[i], 1'b1};
        end else if (iv_count >= MaxIntervals) begin
            w = '{KindAck, StDropped, 16'd0, 16'd0, 1'b1};
        end else begin
            for (j = iv_count; j > i; j--) begin
                iv_lo[j] = iv_lo[j-1];
                iv_hi[j] = iv_hi[j-1];
            end
            iv_lo[i] = v;
            iv_hi[i] = v;
            iv_count++;
            w = '{KindAck, StNew, v, v, 1'b1};
        end
        expected_words.push_back(w);
    endfunction

    function automatic t_cmd add_cmd(input t_value v);
        return '{OpAdd, v};
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                track_command('{cmd_ch.operation, cmd_ch.add_value});
                void'(pending_cmds.pop_front());
            end
            if ((!cmd_ch.valid || cmd_ch.ready) ) begin
                if (cmd_ch.valid && cmd_ch.ready && pending_cmds.size() == 0) begin
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             $urandom_range(99) >= send_idle_pct) begin
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.operation <= pending_cmds[0].op;
                    cmd_ch.add_value <= pending_cmds[0].value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.result_kind, res_ch.add_status, res_ch.range_start,
                        res_ch.range_end, res_ch.last_of_run};
                words_checked++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d status %0d %0d..%0d last %0d",
                                 got.kind, got.status, got.lo, got.hi, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want k%0d s%0d %0d..%0d l%0d, got k%0d s%0d %0d..%0d l%0d",
                                     want.kind, want.status, want.lo, want.hi, want.last,
                                     got.kind, got.status, got.lo, got.hi, got.last);
                    end
                end
            end
            if (quiet_cycles >= StallLimit) begin
                $display("watchdog: no progress for %0d cycles", StallLimit);
                $display("disjoint_interval_tracker_core_tb: errors");
                $finish;
            end
        end
    end

    task automatic push_random(input int count);
        int k;
        t_value base;
        base = t_value'($urandom);
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0:       pending_cmds.push_back('{OpReport, t_value'($urandom)});
                1:       pending_cmds.push_back(add_cmd(t_value'($urandom)));
                2:       base = t_value'($urandom);
                default: pending_cmds.push_back(add_cmd(base + t_value'($urandom_range(40))));
            endcase
        end
        pending_cmds.push_back('{OpReport, 16'd0});
    endtask

    task automatic drain;
        int k;
        while (pending_cmds.size() != 0 || expected_words.size() != 0 || cmd_ch.valid)
            @(posedge i_clk);
        for (k = 0; k < 40; k++) @(posedge i_clk);
    endtask

    initial begin
        int k;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = OpAdd;
        cmd_ch.add_value = '0;
        res_ch.ready = 1'b0;
        iv_count = 0;
        mismatches = 0;
        send_idle_pct = 22;
        recv_idle_pct = 75;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty report, both ends of the range, covering, joins on each side.
        pending_cmds.push_back('{OpReport, 16'hFFFF});
        pending_cmds.push_back(add_cmd(16'd0));
        pending_cmds.push_back(add_cmd(16'hFFFF));
        pending_cmds.push_back(add_cmd(16'd0));
        pending_cmds.push_back(add_cmd(16'd1));
        pending_cmds.push_back(add_cmd(16'hFFFE));
        pending_cmds.push_back(add_cmd(16'd10));
        pending_cmds.push_back(add_cmd(16'd12));
        pending_cmds.push_back(add_cmd(16'd11));
        pending_cmds.push_back(add_cmd(16'd9));
        pending_cmds.push_back(add_cmd(16'h5555));
        pending_cmds.push_back(add_cmd(16'hAAAA));
        pending_cmds.push_back('{OpReport, 16'h0000});
        // Fill the table with isolated values, then overflow it.
        for (k = 0; k < 12; k++)
            pending_cmds.push_back(add_cmd(t_value'(1000 + 4 * k)));
        pending_cmds.push_back(add_cmd(16'd3000));
        pending_cmds.push_back('{OpReport, 16'd0});
        pending_cmds.push_back(add_cmd(16'd1001));
        push_random(60);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 22;
        push_random(60);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(60);
        drain();

        $display("covered %0d adds and %0d reports, %0d result words checked",
                 adds_seen, reports_seen, words_checked);
        $display("table ended with %0d intervals", iv_count);
        if (mismatches == 0) begin
            $display("disjoint_interval_tracker_core_tb: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("disjoint_interval_tracker_core_tb: errors");
        end
        $finish;
    end
endmodule
